// ===== rtl/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types, constants and helper functions of the three-component vector
// arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int NUM_LANES   = 6;
	localparam int SQRT_STAGES = DATA_W;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [2:0] {
		CMD_SCALE   = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_SUB     = 3'd2,
		CMD_DOT     = 3'd3,
		CMD_CROSS   = 3'd4,
		CMD_NORM    = 3'd5,
		CMD_WEDGE   = 3'd6,
		CMD_INVALID = 3'd7
	} cmd_t;

	// Results of one request travelling alongside the root pipeline.
	typedef struct packed {
		cmd_t                          cmd;
		logic [NUM_LANES-1:0][DATA_W-1:0] r;
		logic                          sat;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} sat_res_t;

	// Clips a wide signed value to the 32-bit signed range.
	function automatic sat_res_t sat32(input logic signed [SUM_W-1:0] v);
		sat_res_t o;
		logic [SUM_W-DATA_W:0] hi;
		hi = v[SUM_W-1:DATA_W-1];
		if (hi == '0 || hi == '1) begin
			o.val = v[DATA_W-1:0];
			o.sat = 1'b0;
		end else begin
			o.val = v[SUM_W-1] ? SAT_MIN : SAT_MAX;
			o.sat = 1'b1;
		end
		return o;
	endfunction

endpackage

// ===== rtl/vec3_arith_unit.sv =====
// Path: a request passes through the product register, the merge register,
// the square root pipeline stages and the output register.
// Throughput: one request per cycle; all stages advance together whenever the
// output register is empty or its result is being taken.
// The pipeline depth is set by the square root pipeline, one root bit per stage.
// Reset: arst_n clears every valid bit at once; payload registers keep no reset.
// ----------------------------------------------------------------------------
// vec3_arith_unit
// Three-component vector ALU in signed Q16.16 with saturating results.
// ----------------------------------------------------------------------------
module vec3_arith_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [2:0]                         cmd,
	input  logic signed [vau_pkg::DATA_W-1:0]  ax,
	input  logic signed [vau_pkg::DATA_W-1:0]  ay,
	input  logic signed [vau_pkg::DATA_W-1:0]  az,
	input  logic signed [vau_pkg::DATA_W-1:0]  bx,
	input  logic signed [vau_pkg::DATA_W-1:0]  by_comp,
	input  logic signed [vau_pkg::DATA_W-1:0]  bz,
	input  logic signed [vau_pkg::DATA_W-1:0]  scalar,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic signed [vau_pkg::DATA_W-1:0]  r0,
	output logic signed [vau_pkg::DATA_W-1:0]  r1,
	output logic signed [vau_pkg::DATA_W-1:0]  r2,
	output logic signed [vau_pkg::DATA_W-1:0]  r3,
	output logic signed [vau_pkg::DATA_W-1:0]  r4,
	output logic signed [vau_pkg::DATA_W-1:0]  r5,
	output logic                               invalid_op,
	output logic                               saturated
);
	import vau_pkg::*;

	// The whole pipeline moves as one; it only holds when a finished result
	// is waiting in the output register and the consumer is not taking it.
	logic adv;
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	cmd_t cmd_in;
	assign cmd_in = cmd_t'(cmd);

	// Operand selection for the six multiplier lanes. Cross and wedge share
	// the same six products; only the merge orders them differently.
	logic signed [NUM_LANES-1:0][DATA_W-1:0] opx, opy;
	always_comb begin
		opx = {bz, by_comp, bx, az, ay, ax};
		opy = {scalar, scalar, scalar, scalar, scalar, scalar};
		case (cmd_in)
			CMD_DOT: begin
				opy = {scalar, scalar, scalar, bz, by_comp, bx};
			end
			CMD_CROSS, CMD_WEDGE: begin
				opx = {ay, ax, ax, az, az, ay};
				opy = {bx, by_comp, bz, bx, by_comp, bz};
			end
			CMD_NORM: begin
				opy = {bz, by_comp, bx, az, ay, ax};
			end
			default: begin
			end
		endcase
	end

	// Stage 1: products, plus the add or subtract result, which needs no lane.
	logic signed [NUM_LANES-1:0][PROD_W-1:0] prod_s1;
	logic signed [2:0][DATA_W:0]             addsub_s1;
	cmd_t                                    cmd_s1;
	logic                                    v_s1;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		vau_mul_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.x    (opx[i]),
			.y    (opy[i]),
			.p_s1 (prod_s1[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_in;
			if (cmd_in == CMD_SUB) begin
				addsub_s1[0] <= (DATA_W+1)'(ax) - (DATA_W+1)'(bx);
				addsub_s1[1] <= (DATA_W+1)'(ay) - (DATA_W+1)'(by_comp);
				addsub_s1[2] <= (DATA_W+1)'(az) - (DATA_W+1)'(bz);
			end else begin
				addsub_s1[0] <= (DATA_W+1)'(ax) + (DATA_W+1)'(bx);
				addsub_s1[1] <= (DATA_W+1)'(ay) + (DATA_W+1)'(by_comp);
				addsub_s1[2] <= (DATA_W+1)'(az) + (DATA_W+1)'(bz);
			end
		end
	end

	// Stage 2: merged, truncated and saturated results, and the radicands.
	side_t             side_m, side_s2;
	logic [PROD_W-1:0] rad_a_m, rad_b_m, rad_a_s2, rad_b_s2;
	logic              v_s2;

	vau_merge u_merge (
		.cmd    (cmd_s1),
		.prod   (prod_s1),
		.addsub (addsub_s1),
		.side   (side_m),
		.rad_a  (rad_a_m),
		.rad_b  (rad_b_m)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2  <= side_m;
			rad_a_s2 <= rad_a_m;
			rad_b_s2 <= rad_b_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
		end
	end

	// Root pipeline: every request passes through it so that order is kept.
	logic              v_sq;
	logic [DATA_W-1:0] root_a, root_b;
	side_t             side_sq;

	vau_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.rad_a     (rad_a_s2),
		.rad_b     (rad_b_s2),
		.side_in   (side_s2),
		.out_valid (v_sq),
		.root_a    (root_a),
		.root_b    (root_b),
		.side_out  (side_sq)
	);

	// Output register. A root can exceed the signed range; it is clipped.
	cmd_t cmd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_q      <= side_sq.cmd;
			invalid_op <= (side_sq.cmd == CMD_INVALID);
			if (side_sq.cmd == CMD_NORM) begin
				r0        <= root_a[DATA_W-1] ? SAT_MAX : root_a;
				r1        <= root_b[DATA_W-1] ? SAT_MAX : root_b;
				r2        <= '0;
				r3        <= '0;
				r4        <= '0;
				r5        <= '0;
				saturated <= root_a[DATA_W-1] | root_b[DATA_W-1];
			end else begin
				r0        <= side_sq.r[0];
				r1        <= side_sq.r[1];
				r2        <= side_sq.r[2];
				r3        <= side_sq.r[3];
				r4        <= side_sq.r[4];
				r5        <= side_sq.r[5];
				saturated <= side_sq.sat;
			end
		end
	end

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && invalid_op |-> r0 == 0 && r1 == 0 && r2 == 0 && !saturated)
		else $error("invalid opcode gave a non-zero result");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cmd_q != CMD_SCALE |-> r3 == 0 && r4 == 0 && r5 == 0)
		else $error("upper results set outside scale");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cmd_q == CMD_NORM |-> !r0[DATA_W-1] && !r1[DATA_W-1] && r2 == 0)
		else $error("norm result out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_sq))
		else $error("pipeline moved while stalled");
`endif

endmodule

// ===== rtl/vau_mul_lane.sv =====
// ----------------------------------------------------------------------------
// vau_mul_lane
// One multiplier lane: a registered 32 x 32 signed product.
// ----------------------------------------------------------------------------
module vau_mul_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [vau_pkg::DATA_W-1:0]    x,
	input  logic signed [vau_pkg::DATA_W-1:0]    y,
	output logic signed [vau_pkg::PROD_W-1:0]    p_s1
);
	import vau_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= x * y;
		end
	end

endmodule

// ===== rtl/vau_merge.sv =====
// ----------------------------------------------------------------------------
// vau_merge
// Combines the lane products into the final sums, truncates and saturates,
// and forms the radicands of the two norms.
// ----------------------------------------------------------------------------
module vau_merge (
	input  vau_pkg::cmd_t                                        cmd,
	input  logic signed [vau_pkg::NUM_LANES-1:0][vau_pkg::PROD_W-1:0] prod,
	input  logic signed [2:0][vau_pkg::DATA_W:0]                 addsub,
	output vau_pkg::side_t                                       side,
	output logic [vau_pkg::PROD_W-1:0]                           rad_a,
	output logic [vau_pkg::PROD_W-1:0]                           rad_b
);
	import vau_pkg::*;

	logic signed [SUM_W-1:0] pe [NUM_LANES];
	logic signed [SUM_W-1:0] sum_a, sum_b;
	logic signed [SUM_W-1:0] diff [3];
	sat_res_t                res [NUM_LANES];

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			pe[i] = SUM_W'($signed(prod[i]));
		end
		sum_a   = pe[0] + pe[1] + pe[2];
		sum_b   = pe[3] + pe[4] + pe[5];
		diff[0] = pe[0] - pe[1];
		diff[1] = pe[2] - pe[3];
		diff[2] = pe[4] - pe[5];
		rad_a   = sum_a[PROD_W-1:0];
		rad_b   = sum_b[PROD_W-1:0];

		for (int i = 0; i < NUM_LANES; i++) begin
			res[i] = '{val: '0, sat: 1'b0};
		end
		case (cmd)
			CMD_SCALE: begin
				for (int i = 0; i < NUM_LANES; i++) begin
					res[i] = sat32(pe[i] >>> FRAC_BITS);
				end
			end
			CMD_ADD, CMD_SUB: begin
				for (int i = 0; i < 3; i++) begin
					res[i] = sat32(SUM_W'($signed(addsub[i])));
				end
			end
			CMD_DOT: begin
				res[0] = sat32(sum_a >>> FRAC_BITS);
			end
			CMD_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					res[i] = sat32(diff[i] >>> FRAC_BITS);
				end
			end
			CMD_WEDGE: begin
				res[0] = sat32(diff[2] >>> FRAC_BITS);
				res[1] = sat32(diff[0] >>> FRAC_BITS);
				res[2] = sat32(diff[1] >>> FRAC_BITS);
			end
			default: begin
			end
		endcase

		side.cmd = cmd;
		side.sat = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			side.r[i] = res[i].val;
			side.sat  = side.sat | res[i].sat;
		end
	end

endmodule

// ===== rtl/vau_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// vau_sqrt_pipe
// Two-lane pipelined integer square root, one result bit per stage, with the
// other results of the request carried alongside.
// ----------------------------------------------------------------------------
module vau_sqrt_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [vau_pkg::PROD_W-1:0]    rad_a,
	input  logic [vau_pkg::PROD_W-1:0]    rad_b,
	input  vau_pkg::side_t                side_in,
	output logic                          out_valid,
	output logic [vau_pkg::DATA_W-1:0]    root_a,
	output logic [vau_pkg::DATA_W-1:0]    root_b,
	output vau_pkg::side_t                side_out
);
	import vau_pkg::*;

	typedef struct packed {
		logic [PROD_W-1:0] n;
		logic [PROD_W-1:0] res;
	} sq_t;

	function automatic sq_t sqrt_step(input sq_t cur, input logic [PROD_W-1:0] bitv);
		sq_t nxt;
		if (cur.n >= cur.res + bitv) begin
			nxt.n   = cur.n - (cur.res + bitv);
			nxt.res = (cur.res >> 1) + bitv;
		end else begin
			nxt.n   = cur.n;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	sq_t   st_a [SQRT_STAGES+1];
	sq_t   st_b [SQRT_STAGES+1];
	side_t sd   [SQRT_STAGES+1];
	logic  vld  [SQRT_STAGES+1];

	assign st_a[0] = '{n: rad_a, res: '0};
	assign st_b[0] = '{n: rad_b, res: '0};
	assign sd[0]   = side_in;
	assign vld[0]  = in_valid;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [PROD_W-1:0] BIT_K = PROD_W'(1) << (PROD_W - 2 - 2 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_a[k+1] <= sqrt_step(st_a[k], BIT_K);
				st_b[k+1] <= sqrt_step(st_b[k], BIT_K);
				sd[k+1]   <= sd[k];
			end
		end
	end

	assign out_valid = vld[SQRT_STAGES];
	assign root_a    = st_a[SQRT_STAGES].res[DATA_W-1:0];
	assign root_b    = st_b[SQRT_STAGES].res[DATA_W-1:0];
	assign side_out  = sd[SQRT_STAGES];

endmodule

// ===== dv/vec3_arith_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec3_arith_unit_tb
// Self-checking bench for the vector arithmetic unit. Requests are driven with
// random gaps and field values. A built-in predictor computes each response
// exactly in wide arithmetic, and a checker compares every accepted response
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module vec3_arith_unit_tb;

	import vau_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 60;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [71:0]       wide_t;

	// One predicted response, laid out as the output ports are.
	typedef struct {
		word_t r [6];
		logic  inv;
		logic  sat;
	} vec_result_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	logic  [2:0] cmd;
	word_t ax, ay, az, bx, by_comp, bz, scalar;
	logic  rsp_valid;
	logic  rsp_ready;
	word_t r0, r1, r2, r3, r4, r5;
	logic  invalid_op;
	logic  saturated;

	vec_result_t pending_results [$];
	int          errors;
	int          requests_sent;
	int          responses_seen;
	int          cycles;
	int          hold_off_cycles;
	bit          idle_on;
	int          cmd_hits [8];

	vec3_arith_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.ax         (ax),
		.ay         (ay),
		.az         (az),
		.bx         (bx),
		.by_comp    (by_comp),
		.bz         (bz),
		.scalar     (scalar),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.r0         (r0),
		.r1         (r1),
		.r2         (r2),
		.r3         (r3),
		.r4         (r4),
		.r5         (r5),
		.invalid_op (invalid_op),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that stops making progress is ended here rather than hanging.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Clips a wide exact value to 32 bits, noting any clipping in the flag.
	function automatic word_t clip32(input wide_t v, inout logic flag);
		if (v > wide_t'(32'sh7fffffff)) begin
			flag = 1'b1;
			return word_t'(SAT_MAX);
		end else if (v < -wide_t'(64'sh80000000)) begin
			flag = 1'b1;
			return word_t'(SAT_MIN);
		end
		return word_t'(v);
	endfunction

	function automatic wide_t full_product(input word_t x, input word_t y);
		wide_t xe;
		wide_t ye;
		xe = x;
		ye = y;
		return xe * ye;
	endfunction

	// Difference of two products, dropped to the fixed-point scale once
	// (the arithmetic shift on a signed value rounds towards minus infinity).
	function automatic wide_t product_diff(input word_t p, input word_t q,
			input word_t u, input word_t w);
		return (full_product(p, q) - full_product(u, w)) >>> FRAC_BITS;
	endfunction

	// Floor of the square root, one result bit per step.
	function automatic wide_t floor_root(input wide_t n);
		wide_t rem;
		wide_t res;
		wide_t bitv;
		rem = n;
		res = '0;
		for (int k = 34; k >= 0; k--) begin
			bitv = wide_t'(1) <<< (2 * k);
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
		end
		return res;
	endfunction

	function automatic wide_t vector_length(input word_t x, input word_t y, input word_t z);
		return floor_root(full_product(x, x) + full_product(y, y) + full_product(z, z));
	endfunction

	function automatic vec_result_t predict_vector_op(input cmd_t op,
			input word_t a [3], input word_t b [3], input word_t s);
		vec_result_t res;
		wide_t       exact [6];
		for (int i = 0; i < 6; i++) exact[i] = '0;
		res.inv = 1'b0;
		res.sat = 1'b0;
		case (op)
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					exact[i]     = full_product(a[i], s) >>> FRAC_BITS;
					exact[3 + i] = full_product(b[i], s) >>> FRAC_BITS;
				end
			end
			CMD_ADD: begin
				for (int i = 0; i < 3; i++) exact[i] = wide_t'(a[i]) + wide_t'(b[i]);
			end
			CMD_SUB: begin
				for (int i = 0; i < 3; i++) exact[i] = wide_t'(a[i]) - wide_t'(b[i]);
			end
			CMD_DOT: begin
				exact[0] = (full_product(a[0], b[0]) + full_product(a[1], b[1])
					+ full_product(a[2], b[2])) >>> FRAC_BITS;
			end
			CMD_CROSS: begin
				exact[0] = product_diff(a[1], b[2], a[2], b[1]);
				exact[1] = product_diff(a[2], b[0], a[0], b[2]);
				exact[2] = product_diff(a[0], b[1], a[1], b[0]);
			end
			CMD_NORM: begin
				exact[0] = vector_length(a[0], a[1], a[2]);
				exact[1] = vector_length(b[0], b[1], b[2]);
			end
			CMD_WEDGE: begin
				exact[0] = product_diff(a[0], b[1], a[1], b[0]);
				exact[1] = product_diff(a[1], b[2], a[2], b[1]);
				exact[2] = product_diff(a[2], b[0], a[0], b[2]);
			end
			default: res.inv = 1'b1;
		endcase
		for (int i = 0; i < 6; i++) res.r[i] = clip32(exact[i], res.sat);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("Mismatch on %s in response %0d: got %0d, expected %0d",
			field, responses_seen, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		vec_result_t want;
		word_t       got [6];
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$display("Response %0d arrived with no request outstanding",
					responses_seen);
				errors++;
			end else begin
				want = pending_results.pop_front();
				got = '{r0, r1, r2, r3, r4, r5};
				for (int i = 0; i < 6; i++)
					if (got[i] !== want.r[i])
						report_mismatch($sformatf("r%0d", i), got[i], want.r[i]);
				if (invalid_op !== want.inv)
					report_mismatch("invalid_op", invalid_op, want.inv);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
			responses_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Response side: random back-pressure, plus an occasional long hold-off.
	// ------------------------------------------------------------------
	initial begin
		int gap;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = idle_on ? $urandom_range(0, 14) : 0;
			if (hold_off_cycles > 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Drives one request, after a random gap while idle_on is set, and records its
	// prediction once it has been accepted.
	task automatic send_vector_op(input cmd_t op, input word_t a [3], input word_t b [3],
			input word_t s);
		int gap;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd       <= op;
		ax        <= a[0];
		ay        <= a[1];
		az        <= a[2];
		bx        <= b[0];
		by_comp   <= b[1];
		bz        <= b[2];
		scalar    <= s;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_results.push_back(predict_vector_op(op, a, b, s));
		requests_sent++;
		cmd_hits[op]++;
	endtask

	// Mixes full-range words with boundary values and modest magnitudes, so
	// that both clipped and unclipped results are common.
	function automatic word_t pick_word();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: return word_t'(SAT_MAX);
					1: return word_t'(SAT_MIN);
					2: return '0;
					3: return -1;
					default: return word_t'(1 << FRAC_BITS);
				endcase
			end
			1, 2: return word_t'($urandom) >>> $urandom_range(8, 20);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_random_op();
		word_t a [3];
		word_t b [3];
		for (int i = 0; i < 3; i++) begin
			a[i] = pick_word();
			b[i] = pick_word();
		end
		send_vector_op(cmd_t'($urandom_range(0, 7)), a, b, pick_word());
	endtask

	// Holds the request side until every outstanding response has arrived.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Boundary operands for every operation, including sums that overflow,
	// norms beyond the range and the unimplemented opcode.
	task automatic test_directed();
		word_t hi [3];
		word_t lo [3];
		word_t zr [3];
		word_t one [3];
		word_t mix [3];
		hi  = '{word_t'(SAT_MAX), word_t'(SAT_MAX), word_t'(SAT_MAX)};
		lo  = '{word_t'(SAT_MIN), word_t'(SAT_MIN), word_t'(SAT_MIN)};
		zr  = '{0, 0, 0};
		one = '{32'sh10000, -32'sh10000, 32'sh8000};
		mix = '{word_t'(SAT_MAX), word_t'(SAT_MIN), -1};
		for (int op = 0; op < 8; op++) send_vector_op(cmd_t'(op), one, mix, 32'sh18000);
		send_vector_op(CMD_SCALE, hi, lo, word_t'(SAT_MIN));
		send_vector_op(CMD_SCALE, lo, one, -1);
		send_vector_op(CMD_ADD, hi, hi, 0);
		send_vector_op(CMD_SUB, lo, hi, 0);
		send_vector_op(CMD_DOT, lo, lo, 0);
		send_vector_op(CMD_DOT, zr, hi, 0);
		send_vector_op(CMD_CROSS, hi, lo, 0);
		send_vector_op(CMD_CROSS, mix, one, 0);
		send_vector_op(CMD_NORM, lo, zr, 0);
		send_vector_op(CMD_NORM, one, hi, 0);
		send_vector_op(CMD_WEDGE, mix, hi, 0);
		send_vector_op(CMD_INVALID, hi, lo, word_t'(SAT_MAX));
		wait_for_drain();
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_random_op();
	endtask

	task automatic test_back_to_back(input int count);
		idle_on = 1'b0;
		repeat (count) send_random_op();
		idle_on = 1'b1;
	endtask

	// The response side stops for a long stretch while requests keep coming,
	// so the pipeline fills and must hold its input.
	task automatic test_long_stall(input int count);
		idle_on = 1'b0;
		hold_off_cycles = 150;
		repeat (count) send_random_op();
		idle_on = 1'b1;
		wait_for_drain();
	endtask

	initial begin
		errors          = 0;
		requests_sent   = 0;
		responses_seen  = 0;
		cycles          = 0;
		hold_off_cycles = 0;
		idle_on         = 1'b1;
		foreach (cmd_hits[i]) cmd_hits[i] = 0;
		arst_n    = 1'b0;
		req_valid <= 1'b0;
		cmd       <= CMD_SCALE;
		ax        <= '0;
		ay        <= '0;
		az        <= '0;
		bx        <= '0;
		by_comp   <= '0;
		bz        <= '0;
		scalar    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(700);
		test_long_stall(100);
		test_back_to_back(200);
		wait_for_drain();
		test_random_mix(700);

		wait_for_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d requests and %0d responses across all eight opcodes",
			requests_sent, responses_seen);
		$display("Per opcode: %0d %0d %0d %0d %0d %0d %0d %0d", cmd_hits[0], cmd_hits[1],
			cmd_hits[2], cmd_hits[3], cmd_hits[4], cmd_hits[5], cmd_hits[6], cmd_hits[7]);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d responses missing", errors, pending_results.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/vau_pkg.sv
rtl/vau_mul_lane.sv
rtl/vau_merge.sv
rtl/vau_sqrt_pipe.sv
rtl/vec3_arith_unit.sv
dv/vec3_arith_unit_tb.sv
